@@ design/ple_pkg.sv @@
// package: sizes, codes and shared types of the positional list engine
package ple_pkg;

   localparam int LIST_CAPACITY = 16;
   localparam int DATA_WIDTH    = 32;
   localparam int ADDR_WIDTH    = $clog2(LIST_CAPACITY);
   localparam int COUNT_WIDTH   = $clog2(LIST_CAPACITY + 1);
   localparam int OP_WIDTH      = 2;
   localparam int POS_WIDTH     = 5;
   localparam int STATUS_WIDTH  = 2;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_READ   = 2'd2,
      OP_WRITE  = 2'd3
   } req_op_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_DONE    = 2'd0,
      ST_BAD_POS = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SHIFT,
      S_DRAIN,
      S_WRITE,
      S_READ,
      S_REPLY
   } state_type;

   typedef struct packed {
      logic                  en;
      logic [ADDR_WIDTH-1:0] addr;
      logic [DATA_WIDTH-1:0] data;
   } ram_wr_type;

endpackage

@@ design/ple_req_if.sv @@
// request channel: valid/ready handshake with the request word
interface ple_req_if;
   logic                           valid;
   logic                           ready;
   logic [ple_pkg::OP_WIDTH-1:0]   req_type;
   logic [ple_pkg::POS_WIDTH-1:0]  position;
   logic [ple_pkg::DATA_WIDTH-1:0] value;

   modport source (output valid, output req_type, output position, output value,
                   input ready);
   modport sink   (input valid, input req_type, input position, input value,
                   output ready);
endinterface

@@ design/ple_rsp_if.sv @@
// response channel: valid/ready handshake with the response word
interface ple_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [ple_pkg::STATUS_WIDTH-1:0] status;
   logic [ple_pkg::DATA_WIDTH-1:0]   read_value;
   logic [ple_pkg::COUNT_WIDTH-1:0]  length;
   logic                             is_empty;

   modport source (output valid, output status, output read_value, output length,
                   output is_empty, input ready);
   modport sink   (input valid, input status, input read_value, input length,
                   input is_empty, output ready);
endinterface

@@ design/ple_list_ram.sv @@
// list storage: one write port, one read port with registered read data
module ple_list_ram (
   input  logic                                clock,
   input  ple_pkg::ram_wr_type                 wr,
   input  logic [ple_pkg::ADDR_WIDTH-1:0]      rd_addr,
   output logic [ple_pkg::DATA_WIDTH-1:0]      rd_data
);

   logic [ple_pkg::DATA_WIDTH-1:0] mem [ple_pkg::LIST_CAPACITY];
   logic [ple_pkg::DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/positional_list_engine.sv @@
// top level: ordered list with positional insert, remove, read and overwrite
//
//   channel  | dir | handshake         | word
//   ---------+-----+-------------------+------------------------------------------
//   req_ch   | in  | valid/ready       | req_type, position, value
//   rsp_ch   | out | valid/ready       | status, read_value, length, is_empty
//
// one request at a time; n = length before the request, p = position
// insert inside the list: shift up, one ram read and write per shifted entry, drain,
// then write the word; remove inside the list: shift down; tail remove and rejected
// request, append, read, overwrite: no shift; one ram port pair sets the shift rate
// reset clears length and state; entries undefined until written, no clearing pass
// a stalled response sits in the output register while the next request is taken
module positional_list_engine (
   input logic        clock,
   input logic        reset,
   ple_req_if.sink    req_ch,
   ple_rsp_if.source  rsp_ch
);

   localparam int AW = ple_pkg::ADDR_WIDTH;
   localparam int CW = ple_pkg::COUNT_WIDTH;
   localparam int PW = ple_pkg::POS_WIDTH;
   localparam int DW = ple_pkg::DATA_WIDTH;

   ple_pkg::state_type  state_ff, state_in;
   ple_pkg::req_op_type op_ff, op_in;
   ple_pkg::status_type status_ff, status_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [AW-1:0]       cursor_ff, cursor_in;
   logic [AW-1:0]       end_ff, end_in;
   logic [AW-1:0]       tgt_ff, tgt_in;
   logic [DW-1:0]       word_ff, word_in;
   logic [DW-1:0]       rd_ff, rd_in;
   logic                pend_ff, pend_in;
   logic [AW-1:0]       wr_addr_ff, wr_addr_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [ple_pkg::STATUS_WIDTH-1:0] rsp_status_ff;
   logic [DW-1:0]       rsp_read_ff;
   logic [CW-1:0]       rsp_length_ff;
   logic                rsp_empty_ff;

   ple_pkg::req_op_type acc_op;
   ple_pkg::ram_wr_type ram_wr;
   logic [AW-1:0]       ram_rd_addr;
   logic [DW-1:0]       ram_rd_data;

   logic          accept;
   logic [PW-1:0] pos_dec;
   logic [AW-1:0] pos_addr;
   logic [CW-1:0] cnt_dec;
   logic          pos_zero;
   logic          ins_ok;
   logic          in_range;
   logic          full;
   logic          ins_go;
   logic          ins_shift;
   logic          rem_go;
   logic          rem_shift;
   logic          rd_go;
   logic          wr_go;
   logic          shift_last;
   logic          rsp_load;

   // request decode
   assign accept    = req_ch.valid && (state_ff == ple_pkg::S_IDLE);
   assign acc_op    = ple_pkg::req_op_type'(req_ch.req_type);
   assign pos_dec   = req_ch.position - PW'(1);
   assign pos_addr  = pos_dec[AW-1:0];
   assign cnt_dec   = count_ff - CW'(1);
   assign pos_zero  = (req_ch.position == '0);
   assign ins_ok    = !pos_zero && ((PW+1)'(req_ch.position) <= (PW+1)'(count_ff) + (PW+1)'(1));
   assign in_range  = !pos_zero && ((PW+1)'(req_ch.position) <= (PW+1)'(count_ff));
   assign full      = (count_ff == CW'(ple_pkg::LIST_CAPACITY));
   assign ins_go    = (acc_op == ple_pkg::OP_INSERT) && ins_ok && !full;
   assign ins_shift = ins_go && ((PW+1)'(req_ch.position) <= (PW+1)'(count_ff));
   assign rem_go    = (acc_op == ple_pkg::OP_REMOVE) && in_range;
   assign rem_shift = rem_go && ((PW+1)'(req_ch.position) != (PW+1)'(count_ff));
   assign rd_go     = (acc_op == ple_pkg::OP_READ) && in_range;
   assign wr_go     = (acc_op == ple_pkg::OP_WRITE) && in_range;
   assign shift_last = (cursor_ff == end_ff);
   assign rsp_load  = (state_ff == ple_pkg::S_REPLY) && (!rsp_valid_ff || rsp_ch.ready);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ple_pkg::S_IDLE: begin
            if (accept) begin
               if (ins_shift || rem_shift) begin
                  state_in = ple_pkg::S_SHIFT;
               end else if (ins_go || wr_go) begin
                  state_in = ple_pkg::S_WRITE;
               end else if (rd_go) begin
                  state_in = ple_pkg::S_READ;
               end else begin
                  state_in = ple_pkg::S_REPLY;
               end
            end
         end
         ple_pkg::S_SHIFT: begin
            if (shift_last) begin
               state_in = (op_ff == ple_pkg::OP_INSERT) ? ple_pkg::S_DRAIN : ple_pkg::S_REPLY;
            end
         end
         ple_pkg::S_DRAIN: state_in = ple_pkg::S_WRITE;
         ple_pkg::S_WRITE: state_in = ple_pkg::S_REPLY;
         ple_pkg::S_READ:  state_in = ple_pkg::S_REPLY;
         ple_pkg::S_REPLY: begin
            if (rsp_load) begin
               state_in = ple_pkg::S_IDLE;
            end
         end
         default: state_in = ple_pkg::S_IDLE;
      endcase
   end

   // datapath next values
   always_comb begin
      op_in      = op_ff;
      status_in  = status_ff;
      count_in   = count_ff;
      cursor_in  = cursor_ff;
      end_in     = end_ff;
      tgt_in     = tgt_ff;
      word_in    = word_ff;
      rd_in      = rd_ff;
      pend_in    = 1'b0;
      wr_addr_in = wr_addr_ff;
      case (state_ff)
         ple_pkg::S_IDLE: begin
            if (accept) begin
               op_in   = acc_op;
               word_in = req_ch.value;
               tgt_in  = pos_addr;
               rd_in   = '0;
               if (acc_op == ple_pkg::OP_INSERT) begin
                  cursor_in = cnt_dec[AW-1:0];
                  end_in    = pos_addr;
                  if (!ins_ok) begin
                     status_in = ple_pkg::ST_BAD_POS;
                  end else if (full) begin
                     status_in = ple_pkg::ST_FULL;
                  end else begin
                     status_in = ple_pkg::ST_DONE;
                  end
               end else begin
                  cursor_in = req_ch.position[AW-1:0];
                  end_in    = cnt_dec[AW-1:0];
                  status_in = in_range ? ple_pkg::ST_DONE : ple_pkg::ST_BAD_POS;
               end
               if (ins_go) begin
                  count_in = count_ff + CW'(1);
               end else if (rem_go) begin
                  count_in = cnt_dec;
               end
            end
         end
         ple_pkg::S_SHIFT: begin
            pend_in = 1'b1;
            if (op_ff == ple_pkg::OP_INSERT) begin
               wr_addr_in = cursor_ff + AW'(1);
               cursor_in  = cursor_ff - AW'(1);
            end else begin
               wr_addr_in = cursor_ff - AW'(1);
               cursor_in  = cursor_ff + AW'(1);
            end
         end
         ple_pkg::S_READ: rd_in = ram_rd_data;
         default: ;
      endcase
   end

   // ram access: shift write-back from the registered read, else a word write
   always_comb begin
      ram_wr.en   = 1'b0;
      ram_wr.addr = tgt_ff;
      ram_wr.data = word_ff;
      if (pend_ff) begin
         ram_wr.en   = 1'b1;
         ram_wr.addr = wr_addr_ff;
         ram_wr.data = ram_rd_data;
      end else if (state_ff == ple_pkg::S_WRITE) begin
         ram_wr.en = 1'b1;
      end
   end

   assign ram_rd_addr  = (state_ff == ple_pkg::S_IDLE) ? pos_addr : cursor_ff;
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ch.ready);

   ple_list_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ple_pkg::S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      status_ff  <= status_in;
      cursor_ff  <= cursor_in;
      end_ff     <= end_in;
      tgt_ff     <= tgt_in;
      word_ff    <= word_in;
      rd_ff      <= rd_in;
      wr_addr_ff <= wr_addr_in;
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_read_ff   <= rd_ff;
         rsp_length_ff <= count_ff;
         rsp_empty_ff  <= (count_ff == '0);
      end
   end

   assign req_ch.ready      = (state_ff == ple_pkg::S_IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.read_value = rsp_read_ff;
   assign rsp_ch.length     = rsp_length_ff;
   assign rsp_ch.is_empty   = rsp_empty_ff;

   a_single_write_port: assert property (@(posedge clock) disable iff (reset)
      !(pend_ff && (state_ff == ple_pkg::S_WRITE)))
      else $error("shift write-back collides with word write");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(ple_pkg::LIST_CAPACITY))
      else $error("length beyond capacity");

   a_full_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == ple_pkg::ST_FULL)
      |-> rsp_length_ff == CW'(ple_pkg::LIST_CAPACITY))
      else $error("full status with spare room");

   a_shift_drains: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ple_pkg::S_SHIFT) |=> pend_ff)
      else $error("shift read without write-back");

endmodule
